### src/sync_frame_parser_checksum_defines.svh
// assertion macros used by the frame parser store module
`ifndef SYNC_FRAME_PARSER_CHECKSUM_DEFINES_SVH
`define SYNC_FRAME_PARSER_CHECKSUM_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define SFPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SFPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// consequent must hold after the antecedent, with the cycle that SFPC_ASSERT_NEXT checks skipped
`define SFPC_ASSERT_SKIP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> ##1 (cons)) \
    else $error(msg);

`endif

### src/sfpc_pkg.sv
// shared types and constants of the sync frame parser
package sfpc_pkg;

  localparam int DEFAULT_BUFFER_DEPTH = 32;
  localparam int MAX_RESULTS          = 32;
  localparam int IDX_W                = 5;
  localparam int OUT_TDATA_W          = 48;
  localparam int CFG_INDEX_W          = 3;
  localparam int CFG_DATA_W           = 16;

  // accepted type nibbles of the address byte
  localparam logic [3:0] KIND_A    = 4'h1;
  localparam logic [3:0] KIND_B    = 4'h2;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SYNC_FIRST    = 3'd0,
    REG_SYNC_SECOND   = 3'd1,
    REG_SYNC_THIRD    = 3'd2,
    REG_OWN_ADDRESS   = 3'd3,
    REG_STATUS_OPCODE = 3'd4,
    REG_STATUS_SIZE   = 3'd5
  } cfg_reg_t;

  // frame verdict codes
  typedef enum logic [1:0] {
    VERDICT_OTHER    = 2'd0,
    VERDICT_STATUS   = 2'd1,
    VERDICT_SIZE_ERR = 2'd2,
    VERDICT_BAD_SUM  = 2'd3
  } verdict_t;

  // readout request from the parser to the buffer
  typedef struct packed {
    logic             start;
    logic             has_payload;
    verdict_t         verdict;
    logic [IDX_W-1:0] last_idx;
  } rd_cmd_t;

  // result fields held in the output register
  typedef struct packed {
    verdict_t         verdict;
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    logic             valid;
    logic             last;
  } result_t;

endpackage

### src/sfpc_store.sv
// payload buffer memory and result readout sequencer
`include "sync_frame_parser_checksum_defines.svh"

module sfpc_store #(
  parameter int BUFFER_DEPTH = sfpc_pkg::DEFAULT_BUFFER_DEPTH,
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [7:0]        wr_data,
  input  sfpc_pkg::rd_cmd_t cmd,
  input  logic              m_ready,
  output logic              m_valid,
  output sfpc_pkg::result_t res,
  output logic              busy
);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FETCH,
    ST_SEND
  } state_t;

  state_t                         state;
  logic [sfpc_pkg::IDX_W-1:0]     out_idx;
  logic [sfpc_pkg::IDX_W-1:0]     idx_next;
  logic [sfpc_pkg::IDX_W-1:0]     last_idx;
  logic [7:0]                     mem [BUFFER_DEPTH];
  logic [7:0]                     rd_data;
  logic                           rd_en;
  logic [AW-1:0]                  rd_addr;

  assign idx_next = out_idx + sfpc_pkg::IDX_W'(1);
  assign busy     = (state != ST_RUN);

  // read request: first byte on a frame start with payload, next byte on each taken beat but the last
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state == ST_RUN && cmd.start && cmd.has_payload) begin
      rd_en = 1'b1;
    end else if (state == ST_SEND && m_ready && !res.last) begin
      rd_en   = 1'b1;
      rd_addr = AW'(idx_next);
    end
  end

  // payload memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // readout sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_RUN;
      m_valid <= 1'b0;
    end else begin
      case (state)
        ST_RUN: begin
          if (cmd.start) begin
            res.verdict <= cmd.verdict;
            last_idx    <= cmd.last_idx;
            out_idx     <= '0;
            if (cmd.has_payload) begin
              state <= ST_FETCH;
            end else begin
              res.data  <= '0;
              res.index <= '0;
              res.valid <= 1'b0;
              res.last  <= 1'b1;
              m_valid   <= 1'b1;
              state     <= ST_SEND;
            end
          end
        end
        ST_FETCH: begin
          res.data  <= rd_data;
          res.index <= out_idx;
          res.valid <= 1'b1;
          res.last  <= (out_idx == last_idx);
          m_valid   <= 1'b1;
          state     <= ST_SEND;
        end
        ST_SEND: begin
          if (m_ready) begin
            m_valid <= 1'b0;
            if (res.last) begin
              state <= ST_RUN;
            end else begin
              out_idx <= idx_next;
              state   <= ST_FETCH;
            end
          end
        end
        default: begin
          state   <= ST_RUN;
          m_valid <= 1'b0;
        end
      endcase
    end
  end

  // checks
  `SFPC_ASSERT_NOW(a_start_when_idle, cmd.start, !busy, "frame completed during readout")
  `SFPC_ASSERT_NOW(a_no_write_in_readout, wr_en, !busy, "buffer written during readout")
  `SFPC_ASSERT_NEXT(a_hold_after_beat, m_valid && m_ready && !res.last, busy, "input released early")
  `SFPC_ASSERT_SKIP(a_index_steps, m_valid && m_ready && !res.last, m_valid && res.index == $past(res.index, 2) + sfpc_pkg::IDX_W'(1), "payload index did not advance")

endmodule

### src/sync_frame_parser_checksum.sv
// sync frame parser: one byte per beat in; out, one beat per stored payload byte or one for an empty or bad frame
// readout: a frame with payload reads its first byte from the buffer on the checksum beat, then loads it
//   into the output register; an empty frame or a bad checksum shows its single result in the cycle after it
// throughput: 1 input byte per cycle while parsing; readout fetches each result through the buffer read
//   port, then holds it until taken, and input is held off from the checksum beat to the last beat
// reset: synchronous, returns to idle with cleared sync history and default registers;
//   the payload buffer is not cleared, every byte read out is written in the same frame

module sync_frame_parser_checksum #(
  parameter int BUFFER_DEPTH = sfpc_pkg::DEFAULT_BUFFER_DEPTH,
  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input stream
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [7:0]                           s_tdata,   // rx_byte [7:0]
  // result stream
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // verdict [1:0], frame_kind [5:2], opcode [13:6], frame_length [29:14],
  // payload_byte [37:30], payload_index [42:38], payload_valid [43], zero [47:44]
  output logic [sfpc_pkg::OUT_TDATA_W-1:0]     m_tdata,
  output logic                                 m_tlast,   // last
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [sfpc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sfpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int MaxOut = (BUFFER_DEPTH < sfpc_pkg::MAX_RESULTS) ?
                          BUFFER_DEPTH : sfpc_pkg::MAX_RESULTS;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ADDR,
    PH_INSTR,
    PH_LENHI,
    PH_LENLO,
    PH_DATA
  } phase_t;

  // configuration registers
  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [7:0]  sync_third;
  logic [3:0]  own_address;
  logic [7:0]  status_opcode;
  logic [15:0] status_size;

  // parser state
  phase_t      phase;
  logic [7:0]  prev_first;
  logic [7:0]  prev_second;
  logic [7:0]  length_high;
  logic [15:0] declared_length;
  logic [15:0] byte_count;
  logic [7:0]  running_sum;
  logic [3:0]  kind_reg;
  logic [7:0]  opcode_reg;

  logic                    in_beat;
  logic                    sync_hit;
  logic                    in_payload;
  logic                    addr_ok;
  logic                    sum_ok;
  logic                    busy;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  sfpc_pkg::rd_cmd_t       cmd;
  sfpc_pkg::verdict_t      good_verdict;
  sfpc_pkg::result_t       res;

  assign cfg_ready = 1'b1;
  assign s_tready  = !busy;
  assign in_beat   = s_tvalid && s_tready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first    <= '0;
      sync_second   <= '0;
      sync_third    <= '0;
      own_address   <= 4'd1;
      status_opcode <= '0;
      status_size   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        sfpc_pkg::REG_SYNC_FIRST:    sync_first    <= cfg_data[7:0];
        sfpc_pkg::REG_SYNC_SECOND:   sync_second   <= cfg_data[7:0];
        sfpc_pkg::REG_SYNC_THIRD:    sync_third    <= cfg_data[7:0];
        sfpc_pkg::REG_OWN_ADDRESS:   own_address   <= cfg_data[3:0];
        sfpc_pkg::REG_STATUS_OPCODE: status_opcode <= cfg_data[7:0];
        sfpc_pkg::REG_STATUS_SIZE:   status_size   <= cfg_data;
        default: ;
      endcase
    end
  end

  // byte decode
  assign sync_hit   = (s_tdata == sync_third) && (prev_second == sync_second) &&
                      (prev_first == sync_first);
  assign in_payload = (byte_count < declared_length);
  assign addr_ok    = (s_tdata == {sfpc_pkg::KIND_A, own_address}) ||
                      (s_tdata == {sfpc_pkg::KIND_B, own_address});
  assign sum_ok     = (running_sum == s_tdata);

  always_comb begin
    good_verdict = sfpc_pkg::VERDICT_OTHER;
    if (opcode_reg == status_opcode) begin
      good_verdict = (declared_length == status_size) ? sfpc_pkg::VERDICT_STATUS :
                                                        sfpc_pkg::VERDICT_SIZE_ERR;
    end
  end

  // payload store write and readout request
  assign wr_en   = in_beat && !sync_hit && (phase == PH_DATA) && in_payload &&
                   (byte_count < 16'(BUFFER_DEPTH));
  assign wr_addr = byte_count[AW-1:0];

  always_comb begin
    cmd.start       = in_beat && !sync_hit && (phase == PH_DATA) && !in_payload;
    cmd.has_payload = sum_ok && (declared_length != 16'd0);
    cmd.verdict     = sum_ok ? good_verdict : sfpc_pkg::VERDICT_BAD_SUM;
    cmd.last_idx    = (declared_length >= 16'(MaxOut)) ?
                      sfpc_pkg::IDX_W'(MaxOut - 1) :
                      declared_length[sfpc_pkg::IDX_W-1:0] - sfpc_pkg::IDX_W'(1);
  end

  // frame parser
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      prev_first      <= '0;
      prev_second     <= '0;
      length_high     <= '0;
      declared_length <= '0;
      byte_count      <= '0;
      running_sum     <= '0;
      kind_reg        <= '0;
      opcode_reg      <= '0;
    end else if (in_beat) begin
      prev_first  <= prev_second;
      prev_second <= s_tdata;
      if (sync_hit) begin
        phase           <= PH_ADDR;
        running_sum     <= '0;
        byte_count      <= '0;
        length_high     <= '0;
        declared_length <= '0;
        kind_reg        <= '0;
        opcode_reg      <= '0;
      end else begin
        case (phase)
          PH_ADDR: begin
            running_sum <= running_sum + s_tdata;
            if (addr_ok) begin
              kind_reg <= s_tdata[7:4];
              phase    <= PH_INSTR;
            end else begin
              phase <= PH_IDLE;
            end
          end
          PH_INSTR: begin
            opcode_reg  <= s_tdata;
            running_sum <= running_sum + s_tdata;
            phase       <= PH_LENHI;
          end
          PH_LENHI: begin
            length_high <= s_tdata;
            running_sum <= running_sum + s_tdata;
            phase       <= PH_LENLO;
          end
          PH_LENLO: begin
            declared_length <= {length_high, s_tdata};
            running_sum     <= running_sum + s_tdata;
            byte_count      <= '0;
            phase           <= PH_DATA;
          end
          PH_DATA: begin
            if (in_payload) begin
              byte_count  <= byte_count + 16'd1;
              running_sum <= running_sum + s_tdata;
            end else begin
              phase <= PH_IDLE;
            end
          end
          PH_IDLE: ;
          default: phase <= PH_IDLE;
        endcase
      end
    end
  end

  sfpc_store #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (s_tdata),
    .cmd     (cmd),
    .m_ready (m_tready),
    .m_valid (m_tvalid),
    .res     (res),
    .busy    (busy)
  );

  // frame fields stay put during readout since no byte is taken then
  assign m_tdata = {4'b0000, res.valid, res.index, res.data, declared_length,
                    opcode_reg, kind_reg, res.verdict};
  assign m_tlast = res.last;

endmodule

### tb/tb.sv
// self-checking testbench for the sync frame parser, with a cycle-free frame predictor
`timescale 1ns / 100ps

module tb;
  import sfpc_pkg::*;

  localparam int BUF_DEPTH        = DEFAULT_BUFFER_DEPTH;
  localparam int BUF_AW           = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int STALL_LIMIT      = 2000;
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 200;

  // how a queued frame is closed
  localparam int SUM_GOOD = 0;
  localparam int SUM_BAD  = 1;
  localparam int SUM_NONE = 2;

  typedef enum logic [2:0] {
    PARSE_IDLE,
    PARSE_ADDR,
    PARSE_INSTR,
    PARSE_LEN_HI,
    PARSE_LEN_LO,
    PARSE_DATA
  } parse_phase_t;

  typedef struct packed {
    verdict_t         verdict;
    logic [3:0]       kind;
    logic [7:0]       opcode;
    logic [15:0]      length;
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    logic             valid;
    logic             last;
  } frame_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata = 8'h00;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // register copies as the predictor sees them
  logic [7:0]  cfg_sync [3] = '{default: 8'h00};
  logic [3:0]  cfg_own = 4'h1;
  logic [7:0]  cfg_status_op = 8'h00;
  logic [15:0] cfg_status_size = 16'h0000;

  // predictor state
  parse_phase_t parse_phase = PARSE_IDLE;
  logic [7:0]   rx_history [2] = '{default: 8'h00};
  logic [7:0]   len_high = 8'h00;
  logic [15:0]  decl_length = 16'h0000;
  logic [15:0]  payload_count = 16'h0000;
  logic [7:0]   running_sum = 8'h00;
  logic [3:0]   frame_kind = 4'h0;
  logic [7:0]   frame_opcode = 8'h00;
  logic [7:0]   payload_copy [BUF_DEPTH] = '{default: 8'h00};

  logic [7:0]    rx_bytes [$];
  frame_result_t pending_results [$];

  logic in_ack = 1'b0;
  int   src_gap = 0;
  int   sink_gap = 0;
  int   hold_left = 0;
  bit   hold_armed = 1'b0;
  bit   hold_done = 1'b0;
  bit   steady_flow = 1'b0;
  int   mismatches = 0;
  int   stalled_cycles = 0;

  sync_frame_parser_checksum #(
    .BUFFER_DEPTH(BUF_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void push_expected(verdict_t v, logic [7:0] d, logic [IDX_W-1:0] i,
                                        logic val, logic lst);
    frame_result_t r;
    r.verdict = v;
    r.kind    = frame_kind;
    r.opcode  = frame_opcode;
    r.length  = decl_length;
    r.data    = d;
    r.index   = i;
    r.valid   = val;
    r.last    = lst;
    pending_results.push_back(r);
  endfunction

  // advance the frame parse by one received byte, queue any results it releases
  function automatic void parse_rx_byte(input logic [7:0] b);
    verdict_t v;
    int       stored;
    if (b == cfg_sync[2] && rx_history[1] == cfg_sync[1] && rx_history[0] == cfg_sync[0]) begin
      // completed sync restarts the frame in any phase, byte not summed
      parse_phase   = PARSE_ADDR;
      running_sum   = 8'h00;
      payload_count = 16'h0000;
      len_high      = 8'h00;
      decl_length   = 16'h0000;
      frame_kind    = 4'h0;
      frame_opcode  = 8'h00;
      foreach (payload_copy[i]) payload_copy[i] = 8'h00;
    end else begin
      case (parse_phase)
        PARSE_ADDR: begin
          if (b == {KIND_A, cfg_own} || b == {KIND_B, cfg_own}) begin
            frame_kind  = b[7:4];
            parse_phase = PARSE_INSTR;
          end else begin
            parse_phase = PARSE_IDLE;
          end
          running_sum += b;
        end
        PARSE_INSTR: begin
          frame_opcode = b;
          running_sum += b;
          parse_phase  = PARSE_LEN_HI;
        end
        PARSE_LEN_HI: begin
          len_high     = b;
          running_sum += b;
          parse_phase  = PARSE_LEN_LO;
        end
        PARSE_LEN_LO: begin
          decl_length   = {len_high, b};
          running_sum  += b;
          payload_count = 16'h0000;
          parse_phase   = PARSE_DATA;
        end
        PARSE_DATA: begin
          if (payload_count < decl_length) begin
            // bytes past the buffer are summed but dropped
            if (int'(payload_count) < BUF_DEPTH)
              payload_copy[payload_count[BUF_AW-1:0]] = b;
            payload_count++;
            running_sum += b;
          end else begin
            if (running_sum == b) begin
              v = VERDICT_OTHER;
              if (frame_opcode == cfg_status_op)
                v = (decl_length == cfg_status_size) ? VERDICT_STATUS : VERDICT_SIZE_ERR;
              stored = (int'(decl_length) > BUF_DEPTH) ? BUF_DEPTH : int'(decl_length);
              if (stored > MAX_RESULTS) stored = MAX_RESULTS;
              if (stored == 0) begin
                push_expected(v, 8'h00, '0, 1'b0, 1'b1);
              end else begin
                for (int i = 0; i < stored; i++)
                  push_expected(v, payload_copy[BUF_AW'(i)], IDX_W'(i), 1'b1,
                                i == stored - 1);
              end
            end else begin
              push_expected(VERDICT_BAD_SUM, 8'h00, '0, 1'b0, 1'b1);
            end
            parse_phase = PARSE_IDLE;
          end
        end
        default: begin
          // idle bytes only shift the sync history
        end
      endcase
    end
    rx_history[0] = rx_history[1];
    rx_history[1] = b;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void queue_sync();
    rx_bytes.push_back(cfg_sync[0]);
    rx_bytes.push_back(cfg_sync[1]);
    rx_bytes.push_back(cfg_sync[2]);
  endfunction

  // sync, header, sent payload bytes and a closing checksum as asked
  function automatic void queue_frame(logic [7:0] addr, logic [7:0] op, logic [15:0] len,
                                      int sent, int sum_mode);
    logic [7:0] sum;
    logic [7:0] b;
    queue_sync();
    sum = addr + op + len[15:8] + len[7:0];
    rx_bytes.push_back(addr);
    rx_bytes.push_back(op);
    rx_bytes.push_back(len[15:8]);
    rx_bytes.push_back(len[7:0]);
    for (int i = 0; i < sent; i++) begin
      b = 8'($urandom);
      rx_bytes.push_back(b);
      sum += b;
    end
    if (sum_mode == SUM_GOOD)
      rx_bytes.push_back(sum);
    else if (sum_mode == SUM_BAD)
      rx_bytes.push_back(sum + 8'($urandom_range(1, 255)));
  endfunction

  // mostly well-formed frames, some noise, foreign addresses and cut-off frames
  function automatic void queue_random_traffic(int budget);
    int          start;
    int          sel;
    int          sent;
    logic [15:0] len;
    logic [7:0]  addr;
    logic [7:0]  op;
    start = rx_bytes.size();
    while (rx_bytes.size() - start < budget) begin
      sel  = $urandom_range(0, 99);
      addr = {($urandom_range(0, 1) != 0) ? KIND_B : KIND_A, cfg_own};
      op   = ($urandom_range(0, 9) < 4) ? cfg_status_op : 8'($urandom);
      if (sel < 8) begin
        repeat ($urandom_range(1, 4)) rx_bytes.push_back(8'($urandom));
      end else if (sel < 16) begin
        do addr = 8'($urandom); while (addr == {KIND_A, cfg_own} || addr == {KIND_B, cfg_own});
        queue_sync();
        rx_bytes.push_back(addr);
      end else if (sel < 24) begin
        len  = 16'($urandom);
        sent = $urandom_range(0, 6);
        if (sent > int'(len)) sent = int'(len);
        queue_frame(addr, op, len, sent, SUM_NONE);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 10 && int'(cfg_status_size) <= 40)
          len = cfg_status_size;
        else if (sel < 18)
          len = 16'($urandom_range(BUF_DEPTH + 1, BUF_DEPTH + 8));
        else
          len = 16'($urandom_range(0, 8));
        queue_frame(addr, op, len, int'(len),
                    ($urandom_range(0, 99) < 15) ? SUM_BAD : SUM_GOOD);
      end
    end
  endfunction

  task automatic write_register(input cfg_reg_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SYNC_FIRST:    cfg_sync[0] = value[7:0];
      REG_SYNC_SECOND:   cfg_sync[1] = value[7:0];
      REG_SYNC_THIRD:    cfg_sync[2] = value[7:0];
      REG_OWN_ADDRESS:   cfg_own = value[3:0];
      REG_STATUS_OPCODE: cfg_status_op = value[7:0];
      REG_STATUS_SIZE:   cfg_status_size = value;
      default: begin
      end
    endcase
  endtask

  task automatic load_settings(logic [7:0] s0, logic [7:0] s1, logic [7:0] s2,
                               logic [3:0] own, logic [7:0] op, logic [15:0] size);
    write_register(REG_SYNC_FIRST, 16'(s0));
    write_register(REG_SYNC_SECOND, 16'(s1));
    write_register(REG_SYNC_THIRD, 16'(s2));
    write_register(REG_OWN_ADDRESS, 16'(own));
    write_register(REG_STATUS_OPCODE, 16'(op));
    write_register(REG_STATUS_SIZE, size);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // all bytes taken, all results seen, then let a dropped frame finish inside the block
  task automatic wait_until_drained();
    while (rx_bytes.size() != 0 || s_tvalid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input beat driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_ack) begin
      // beat still waiting for ready
    end else if (src_gap > 0) begin
      src_gap  <= src_gap - 1;
      s_tvalid <= 1'b0;
    end else if (rx_bytes.size() == 0) begin
      s_tvalid <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 11) == 0) begin
      src_gap  <= $urandom_range(0, 15);
      s_tvalid <= 1'b0;
    end else begin
      s_tvalid <= 1'b1;
      s_tdata  <= rx_bytes.pop_front();
    end
  end

  // result ready driver with random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      m_tready <= 1'b0;
    end else if (!steady_flow && $urandom_range(0, 11) == 0) begin
      sink_gap <= $urandom_range(0, 15);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // input monitor feeds the predictor
  always @(posedge clk) begin
    if (rst) begin
      in_ack <= 1'b0;
    end else begin
      in_ack <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) parse_rx_byte(s_tdata);
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no frame result expected, tdata 0x%0h", m_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("verdict", 16'(want.verdict), 16'(m_tdata[1:0]));
        compare_field("frame_kind", 16'(want.kind), 16'(m_tdata[5:2]));
        compare_field("opcode", 16'(want.opcode), 16'(m_tdata[13:6]));
        compare_field("frame_length", want.length, m_tdata[29:14]);
        compare_field("payload_byte", 16'(want.data), 16'(m_tdata[37:30]));
        compare_field("payload_index", 16'(want.index), 16'(m_tdata[42:38]));
        compare_field("payload_valid", 16'(want.valid), 16'(m_tdata[43]));
        compare_field("last", 16'(want.last), 16'(m_tlast));
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    logic [7:0] tail_sum;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers at their reset values
    queue_random_traffic(30);
    wait_until_drained();

    // directed frames
    load_settings(8'hA5, 8'h5A, 8'h7E, 4'h3, 8'h42, 16'h0000);
    // status frame, empty payload, good checksum
    queue_frame({KIND_A, cfg_own}, cfg_status_op, 16'd0, 0, SUM_GOOD);
    // other frame, empty payload, bad checksum
    queue_frame({KIND_B, cfg_own}, 8'h99, 16'd0, 0, SUM_BAD);
    // foreign type nibble drops the frame
    queue_sync();
    rx_bytes.push_back({4'h3, cfg_own});
    // payload ends in the first two sync bytes, the third lands in the checksum slot
    queue_frame({KIND_A, cfg_own}, cfg_status_op, 16'd2, 0, SUM_NONE);
    queue_sync();
    // restarted status frame whose length misses status_size
    tail_sum = {KIND_B, cfg_own} + cfg_status_op + 8'h02 + 8'h00 + 8'hFF;
    rx_bytes.push_back({KIND_B, cfg_own});
    rx_bytes.push_back(cfg_status_op);
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'h02);
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'hFF);
    rx_bytes.push_back(tail_sum);
    wait_until_drained();

    // random settings, with the receiver holding off once
    load_settings(8'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
                  8'($urandom), 16'($urandom_range(0, 8)));
    hold_armed = 1'b1;
    queue_random_traffic(70);
    wait_until_drained();

    // top extremes
    load_settings(8'hFF, 8'hFF, 8'hFF, 4'hF, 8'hFF, 16'hFFFF);
    queue_random_traffic(45);
    wait_until_drained();

    // bottom extremes, no idling to the end
    load_settings(8'h00, 8'h00, 8'h00, 4'h0, 8'h00, 16'h0000);
    steady_flow = 1'b1;
    queue_random_traffic(45);
    wait_until_drained();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/sfpc_pkg.sv
src/sfpc_store.sv
src/sync_frame_parser_checksum.sv
tb/tb.sv
